/* rtl/fpr_pkg.sv */
// shared types and constants of the framed packet receiver
// no dependencies; imported by fpr_deframe and framed_packet_receiver
`default_nettype none

package fpr_pkg;

  // result kinds carried on out_tuser
  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_LEN_ERR = 2'd1;
  localparam logic [1:0] ST_CHK_ERR = 2'd2;

  localparam logic [7:0] HEADER_RESET = 8'hAA;
  localparam logic [7:0] CHK_BASE     = 8'hFF;

  // what the deframer decided for the byte in front of it
  typedef struct packed {
    logic err_len;  // length byte too large
    logic err_chk;  // checksum byte did not match
    logic good;     // checksum matched, frame ready to release
  } fpr_act_t;

endpackage

`default_nettype wire

/* rtl/fpr_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/fpr_deframe.sv */
// frame parser: header hunt, length check, running sum, checksum compare
// depends on fpr_pkg
`default_nettype none

module fpr_deframe #(
  parameter int BUFFER_BYTES = 64,
  parameter int PW = $clog2(BUFFER_BYTES + 2),
  parameter int LW = $clog2(BUFFER_BYTES)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,       // consume byte_in this cycle
  input  wire logic [7:0]       byte_in,
  input  wire logic [PW-1:0]    pos,        // ring position of byte_in
  input  wire logic [7:0]       header,
  output      fpr_pkg::fpr_act_t act,
  output      logic [LW-1:0]    len,        // payload length of current frame
  output      logic [PW-1:0]    base        // ring position of the length byte
);
  import fpr_pkg::*;

  typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_PAY, PH_CHK} phase_t;

  phase_t        phase_r, phase_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [PW-1:0] base_r, base_nxt;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    base_nxt  = base_r;
    act       = '0;
    unique case (phase_r)
      PH_HUNT: begin
        if (byte_in == header) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (9'(byte_in) >= 9'(BUFFER_BYTES)) begin
          act.err_len = 1'b1;
          phase_nxt   = PH_HUNT;
        end else begin
          len_nxt   = byte_in[LW-1:0];
          idx_nxt   = '0;
          sum_nxt   = '0;
          base_nxt  = pos;
          phase_nxt = (byte_in == 8'd0) ? PH_CHK : PH_PAY;
        end
      end
      PH_PAY: begin
        sum_nxt = sum_r + byte_in;
        idx_nxt = idx_r + LW'(1);
        if ((LW+1)'(idx_r) + (LW+1)'(1) >= (LW+1)'(len_r)) begin
          phase_nxt = PH_CHK;
        end
      end
      PH_CHK: begin
        phase_nxt = PH_HUNT;
        if (byte_in == (CHK_BASE - sum_r)) begin
          act.good = 1'b1;
        end else begin
          act.err_chk = 1'b1;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
      base_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      base_r  <= base_nxt;
    end
  end

  assign len  = len_r;
  assign base = base_r;

endmodule

`default_nettype wire

/* rtl/framed_packet_receiver.sv */
// top level of the framed packet receiver: byte ring, sequencer, result register
// depends on fpr_pkg, fpr_ram and fpr_deframe
`default_nettype none

// Takes one received byte per transfer and hunts for a frame: header byte,
// length byte (below BUFFER_BYTES), payload, then a checksum byte equal to
// 0xFF minus the 8-bit payload sum. A good frame releases its payload in order
// on the result channel with tlast on the final byte; an empty good frame gives
// nothing. A bad length or checksum gives one error result (status on tuser,
// tlast set, data zero), drops the header and rescans the bytes that followed
// it. All received bytes go into a ring memory of 2**clog2(BUFFER_BYTES+2)
// entries; a rescan just rewinds the ring's read pointer. An input byte that
// needs no rescan is parsed straight from the port; every rescanned byte and
// every released payload byte is read through the registered ring read port.
// in_tready stays low until the ring has been consumed. The header value must
// be written through the cfg port only while the block is idle; the block
// itself does not enforce this. No clearing pass is needed after reset.
module framed_packet_receiver #(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [7:0] cfg_data,     // header_value
  // received bytes
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,     // [7:0] rx_byte
  // results
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,    // [7:0] payload_byte
  output      logic [1:0] out_tuser,    // [1:0] frame_status
  output      logic       out_tlast     // last_of_frame
);
  import fpr_pkg::*;

  localparam int PW    = $clog2(BUFFER_BYTES + 2);
  localparam int LW    = $clog2(BUFFER_BYTES);
  localparam int DEPTH = 1 << PW;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_PROC, S_EMIT_RD, S_EMIT_OUT} state_t;

  state_t        state_r, state_nxt;
  logic [PW-1:0] rd_r, rd_nxt;      // next ring byte to parse
  logic [PW-1:0] wr_r, wr_nxt;      // next free ring entry
  logic [LW-1:0] k_r, k_nxt;        // payload byte being released
  logic [7:0]    header_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic [1:0]    out_user_r, out_user_nxt;
  logic          out_last_r, out_last_nxt;

  logic          out_free;
  logic          in_xfer;
  logic          step;
  logic [7:0]    step_byte;
  logic [PW-1:0] wr_step;
  logic [PW-1:0] rd_after;
  logic          last_k;
  logic          ram_re;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  fpr_act_t      act;
  logic [LW-1:0] frm_len;
  logic [PW-1:0] frm_base;

  // result register can take a new result this cycle
  assign out_free  = !out_valid_r || out_tready;
  // new bytes only once the ring has been fully parsed
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // a byte is parsed straight from the port, or from the ring on a rescan
  assign step      = in_xfer || ((state_r == S_PROC) && out_free);
  assign step_byte = (state_r == S_IDLE) ? in_tdata : ram_rdata;
  assign wr_step   = wr_r + (in_xfer ? PW'(1) : PW'(0));
  assign last_k    = ((LW+1)'(k_r) + (LW+1)'(1)) == (LW+1)'(frm_len);

  fpr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wr_r),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpr_deframe #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .PW           (PW),
    .LW           (LW)
  ) u_deframe (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (step_byte),
    .pos     (rd_r),
    .header  (header_r),
    .act     (act),
    .len     (frm_len),
    .base    (frm_base)
  );

  always_comb begin
    state_nxt     = state_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_step;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    ram_re        = 1'b0;
    ram_raddr     = rd_r;
    rd_after      = rd_r + PW'(1);

    // rewind targets: the rejected length byte itself, or the frame from its length byte
    if (act.err_len) begin
      rd_after = rd_r;
    end else if (act.err_chk) begin
      rd_after = frm_base;
    end

    unique case (state_r)
      S_IDLE, S_PROC: begin
        if (step) begin
          rd_nxt = rd_after;
          if (act.err_len || act.err_chk) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_user_nxt  = act.err_len ? ST_LEN_ERR : ST_CHK_ERR;
            out_last_nxt  = 1'b1;
          end
          if (act.good && (frm_len != '0)) begin
            k_nxt     = '0;
            state_nxt = S_EMIT_RD;
          end else begin
            state_nxt = (rd_after == wr_step) ? S_IDLE : S_RD;
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rd_r;
        state_nxt = S_PROC;
      end
      S_EMIT_RD: begin
        // payload byte k sits right after the length byte
        ram_re    = 1'b1;
        ram_raddr = frm_base + PW'(k_r) + PW'(1);
        state_nxt = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ram_rdata;
          out_user_nxt  = ST_PAYLOAD;
          out_last_nxt  = last_k;
          k_nxt         = k_r + LW'(1);
          if (last_k) begin
            state_nxt = (rd_r == wr_r) ? S_IDLE : S_RD;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_r        <= '0;
      wr_r        <= '0;
      k_r         <= '0;
      header_r    <= HEADER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        header_r <= cfg_data;
      end
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // input is only taken once the ring has been parsed to the end
  a_idle_ring_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (rd_r == wr_r))
    else $error("input taken with unparsed ring bytes");

  // a ring read is always followed by its parse cycle
  a_rd_then_proc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_PROC))
    else $error("ring read not followed by parse");

  // error results carry tlast and zero data
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_PAYLOAD)) |-> (out_tlast && (out_tdata == 8'd0)))
    else $error("malformed error result");

  // unparsed bytes never exceed one frame span
  a_ring_span: assert property (@(posedge clk) disable iff (!rst_n)
    (PW'(wr_r - rd_r)) <= PW'(BUFFER_BYTES + 1))
    else $error("ring span overrun");
`endif

endmodule

`default_nettype wire
